### rtl/bepc_pkg.sv
// Shared types and constants for the button edge press classifier.
// No dependencies; imported by every module in rtl/.
package bepc_pkg;

    localparam int TS_W    = 32;
    localparam int TICK_W  = 16;
    localparam int TALLY_W = 8;
    localparam int IDX_W   = 3;

    typedef enum logic [2:0] {
        EV_RELEASE = 3'd0,
        EV_SHORT   = 3'd1,
        EV_DOUBLE  = 3'd2,
        EV_LONG    = 3'd3,
        EV_LONG3   = 3'd4,
        EV_LONG5   = 3'd5
    } press_class_t;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [IDX_W-1:0] REG_LONG     = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG3    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LONG5    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WINDOW   = 3'd4;

    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [TICK_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [TICK_W-1:0] LONG3_RST    = 16'd3000;
    localparam logic [TICK_W-1:0] LONG5_RST    = 16'd5000;
    localparam logic [TICK_W-1:0] WINDOW_RST   = 16'd300;

    localparam logic [TALLY_W-1:0] DOUBLE_MIN_TALLY = 8'd2;
    localparam logic [TALLY_W-1:0] TALLY_MAX        = 8'd255;

    // Thresholds as seen by the classifier.
    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] long3_ticks;
        logic [TICK_W-1:0] long5_ticks;
        logic [TICK_W-1:0] double_window_ticks;
    } cfg_t;

endpackage

### rtl/bepc_cfg_regs.sv
// Threshold register file for the press classifier.
// Depends on bepc_pkg.
module bepc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bepc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bepc_pkg::TICK_W-1:0] cfg_wdata,
    output bepc_pkg::cfg_t              cfg
);
    import bepc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_next.debounce_ticks      = cfg_wdata;
                REG_LONG:     cfg_next.long_ticks          = cfg_wdata;
                REG_LONG3:    cfg_next.long3_ticks         = cfg_wdata;
                REG_LONG5:    cfg_next.long5_ticks         = cfg_wdata;
                REG_WINDOW:   cfg_next.double_window_ticks = cfg_wdata;
                default:      cfg_next = cfg_reg; // unused index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks      <= DEBOUNCE_RST;
            cfg_reg.long_ticks          <= LONG_RST;
            cfg_reg.long3_ticks         <= LONG3_RST;
            cfg_reg.long5_ticks         <= LONG5_RST;
            cfg_reg.double_window_ticks <= WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/bepc_core.sv
// Press state and combinational edge classification.
// Depends on bepc_pkg.
module bepc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        edge_kind,
    input  logic [bepc_pkg::TS_W-1:0]   timestamp,
    input  bepc_pkg::cfg_t              cfg,
    output bepc_pkg::press_class_t      press_class
);
    import bepc_pkg::*;

    logic [TS_W-1:0]    first_press_ts_reg, first_press_ts_next;
    logic [TS_W-1:0]    press_start_ts_reg, press_start_ts_next;
    logic [TALLY_W-1:0] press_tally_reg, press_tally_next;
    press_class_t       last_event_reg, last_event_next;
    logic               pending_reg, pending_next;

    logic [TS_W-1:0]    since_first;
    logic [TS_W-1:0]    hold;

    assign since_first = timestamp - first_press_ts_reg;
    assign hold        = timestamp - press_start_ts_reg;

    always_comb
    begin
        first_press_ts_next = first_press_ts_reg;
        press_start_ts_next = press_start_ts_reg;
        press_tally_next    = press_tally_reg;
        last_event_next     = last_event_reg;
        pending_next        = pending_reg;

        if (!edge_kind)
        begin
            // Press: extend the sequence inside the window, else restart it.
            if (since_first <= {{(TS_W-TICK_W){1'b0}}, cfg.double_window_ticks})
            begin
                if (press_tally_reg != TALLY_MAX)
                    press_tally_next = press_tally_reg + 1'b1;
            end
            else
            begin
                press_tally_next    = {{(TALLY_W-1){1'b0}}, 1'b1};
                first_press_ts_next = timestamp;
            end
            press_start_ts_next = timestamp;
            pending_next        = 1'b1;
        end
        else if (pending_reg)
        begin
            pending_next = 1'b0;
            if (hold < {{(TS_W-TICK_W){1'b0}}, cfg.debounce_ticks})
            begin
                last_event_next = EV_RELEASE;
            end
            else if (hold > {{(TS_W-TICK_W){1'b0}}, cfg.long_ticks})
            begin
                if (hold > {{(TS_W-TICK_W){1'b0}}, cfg.long5_ticks})
                    last_event_next = EV_LONG5;
                else if (hold > {{(TS_W-TICK_W){1'b0}}, cfg.long3_ticks})
                    last_event_next = EV_LONG3;
                else
                    last_event_next = EV_LONG;
                press_tally_next = '0;
            end
            else if (press_tally_reg >= DOUBLE_MIN_TALLY)
            begin
                last_event_next  = EV_DOUBLE;
                press_tally_next = '0;
            end
            else
            begin
                last_event_next     = EV_SHORT;
                first_press_ts_next = timestamp;
            end
        end
    end

    // Result of a release, valid in the cycle the item is stepped.
    assign press_class = last_event_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_press_ts_reg <= '0;
            press_start_ts_reg <= '0;
            press_tally_reg    <= '0;
            last_event_reg     <= EV_RELEASE;
            pending_reg        <= 1'b0;
        end
        else if (step)
        begin
            first_press_ts_reg <= first_press_ts_next;
            press_start_ts_reg <= press_start_ts_next;
            press_tally_reg    <= press_tally_next;
            last_event_reg     <= last_event_next;
            pending_reg        <= pending_next;
        end
    end

    // A pending press always belongs to a sequence of at least one press.
    a_pending_tally: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (press_tally_reg != '0))
        else $error("pending press with empty tally");

endmodule

### rtl/button_edge_press_classifier_top.sv
// Top level of the button edge press classifier.
// Depends on bepc_pkg, bepc_cfg_regs and bepc_core.
// Usage:
//   Slave channel s_*: one word per button edge. s_tuser is the edge kind
//   (0 press, 1 release), s_tdata the 32-bit tick timestamp of the edge.
//   Master channel m_*: one word per release, press_class in m_tdata[2:0]
//   (release, short, double, long, long3, long5). Presses give no word.
//   cfg_*: write thresholds by index (0 debounce, 1 long, 2 long3, 3 long5,
//   4 double window); write only while the block is idle.
// Timing:
//   An accepted edge sits in the input register and is classified there
//   against the press state; a release advances into the output register,
//   which drives m_tvalid. Throughput is one edge per cycle while no release
//   is stalled, set by the single classify stage: the press state updates in
//   the same cycle the item leaves the input register.
// Reset:
//   Thresholds return to 20/1000/3000/5000/300 ticks; press state and both valid bits clear.
// Stall:
//   While m_tready is low with a word held, a queued release waits in the
//   input register and s_tready drops; a queued press still advances.
module button_edge_press_classifier_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] timestamp
    input  logic                        s_tuser,   // [0] edge_kind
    // master stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [2:0] press_class, [7:3] zero
    // configuration writes
    input  logic                        cfg_we,
    input  logic [bepc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bepc_pkg::TICK_W-1:0] cfg_wdata
);
    import bepc_pkg::*;

    cfg_t            cfg;
    press_class_t    core_event;

    // input register
    logic            s1_valid_reg, s1_valid_next;
    logic            s1_edge_reg;
    logic [TS_W-1:0] s1_ts_reg;

    // output register
    logic            out_valid_reg, out_valid_next;
    press_class_t    out_event_reg;

    logic            advance;
    logic            load_out;

    bepc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bepc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .edge_kind   (s1_edge_reg),
        .timestamp   (s1_ts_reg),
        .cfg         (cfg),
        .press_class (core_event)
    );

    // Advance a press always; advance a release only into a free output slot.
    assign advance  = s1_valid_reg && (!s1_edge_reg || !out_valid_reg || m_tready);
    assign load_out = advance && s1_edge_reg;
    assign s_tready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_tvalid && s_tready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_edge_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s_tvalid && s_tready)
                s1_edge_reg <= s_tuser;
        end
    end

    // Payload: input holds unless a new word is taken, output unless a release advances.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            s1_ts_reg <= s_tdata;
        if (load_out)
            out_event_reg <= core_event;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_event_reg};

    // Checks on the stage handoff.
    a_release_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_edge_reg && advance) |=> m_tvalid)
        else $error("release advanced without a result");

    a_press_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_edge_reg && (!out_valid_reg || m_tready)) |=> !m_tvalid)
        else $error("press produced a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_edge_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked release");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= EV_LONG5))
        else $error("press class code out of range");

endmodule

### dv/button_edge_press_classifier_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_edge_press_classifier_top.
// Depends on rtl/bepc_pkg.sv and all RTL in rtl/; reads no files.
module button_edge_press_classifier_top_tb;

    import bepc_pkg::*;

    localparam bit EDGE_PRESS   = 1'b0;
    localparam bit EDGE_RELEASE = 1'b1;
    localparam int N_PHASES     = 8;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic              kind;
        logic [TS_W-1:0]   ts;
    } edge_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata = '0;   // [31:0] timestamp
    logic               s_tuser = 1'b0; // [0] edge_kind
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;        // [2:0] press_class, [7:3] zero
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [TICK_W-1:0]  cfg_wdata = '0;

    // Edges waiting to be driven, and press classes the block still owes us.
    edge_word_t         edge_q[$];
    press_class_t       event_q[$];

    // Idle percentages for each side, changed between phases.
    int                 src_idle_pct = 0;
    int                 snk_idle_pct = 0;
    int                 fail_count = 0;

    // Shadow of the thresholds and press state.
    cfg_t               thr;
    logic [TS_W-1:0]    first_ts;
    logic [TS_W-1:0]    start_ts;
    logic [TALLY_W-1:0] tally;
    press_class_t       last_ev;
    logic               press_open;

    // Running tick count used to build plausible edge sequences.
    logic [TS_W-1:0]    now_ts;
    edge_word_t         next_word;
    press_class_t       want_ev;
    cfg_t               phase_cfg[N_PHASES];

    button_edge_press_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Advance the press state by one accepted edge; a release owes one class.
    function automatic void classify_edge(input logic kind, input logic [TS_W-1:0] ts);
        logic [TS_W-1:0] hold;
        if (kind == EDGE_PRESS)
        begin
            // Presses inside the window of the first press extend the tally.
            if (ts - first_ts <= {16'd0, thr.double_window_ticks})
            begin
                if (tally != TALLY_MAX)
                    tally = tally + 1'b1;
            end
            else
            begin
                tally    = 8'd1;
                first_ts = ts;
            end
            start_ts   = ts;
            press_open = 1'b1;
            return;
        end
        if (press_open)
        begin
            hold       = ts - start_ts;
            press_open = 1'b0;
            if (hold < {16'd0, thr.debounce_ticks})
                last_ev = EV_RELEASE;
            else if (hold > {16'd0, thr.long_ticks})
            begin
                // long5 is tested before long3, thresholds taken as written
                if (hold > {16'd0, thr.long5_ticks})
                    last_ev = EV_LONG5;
                else if (hold > {16'd0, thr.long3_ticks})
                    last_ev = EV_LONG3;
                else
                    last_ev = EV_LONG;
                tally = '0;
            end
            else if (tally >= DOUBLE_MIN_TALLY)
            begin
                last_ev = EV_DOUBLE;
                tally   = '0;
            end
            else
            begin
                last_ev  = EV_SHORT;
                first_ts = ts;
            end
        end
        // A release with nothing pending just repeats the last class.
        event_q.push_back(last_ev);
    endfunction

    // Driver: hold a word until taken, then offer the next one or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                classify_edge(s_tuser, s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (edge_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    next_word = edge_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_word.kind;
                    s_tdata  <= next_word.ts;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each press class word against the oldest owed class.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (event_q.size() == 0)
                begin
                    $error("press_class word %0d arrived with none expected", m_tdata[2:0]);
                    fail_count++;
                end
                else
                begin
                    want_ev = event_q.pop_front();
                    if (m_tdata[2:0] !== want_ev)
                    begin
                        $error("press_class mismatch: expected %0d (%s) actual %0d",
                               want_ev, want_ev.name(), m_tdata[2:0]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic push_edge(input logic kind, input logic [TS_W-1:0] ts);
        edge_word_t w;
        w.kind = kind;
        w.ts   = ts;
        edge_q.push_back(w);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic write_thresholds(input cfg_t c);
        thr = c;
        write_reg(REG_DEBOUNCE, c.debounce_ticks);
        write_reg(REG_LONG,     c.long_ticks);
        write_reg(REG_LONG3,    c.long3_ticks);
        write_reg(REG_LONG5,    c.long5_ticks);
        write_reg(REG_WINDOW,   c.double_window_ticks);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every edge to be taken and every class to come back, then let
    // a press that is still inside the block settle.
    task automatic drain;
        wait (edge_q.size() == 0 && !s_tvalid);
        wait (event_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold times clustered around the threshold boundaries.
    function automatic logic [TS_W-1:0] pick_hold;
        case ($urandom_range(0, 11))
            0:  return {16'd0, thr.debounce_ticks} - 1;
            1:  return {16'd0, thr.debounce_ticks};
            2:  return {16'd0, thr.long_ticks};
            3:  return {16'd0, thr.long_ticks} + 1;
            4:  return {16'd0, thr.long3_ticks};
            5:  return {16'd0, thr.long3_ticks} + 1;
            6:  return {16'd0, thr.long5_ticks};
            7:  return {16'd0, thr.long5_ticks} + 1;
            8:  return $urandom_range(0, 70000);
            9:  return $urandom;
            default: return $urandom_range(0, 2 * thr.long_ticks + 2);
        endcase
    endfunction

    // Gap from a release to the next press; mostly near the double window.
    function automatic logic [TS_W-1:0] pick_gap;
        case ($urandom_range(0, 6))
            0, 1: return $urandom_range(0, thr.double_window_ticks);
            2:    return {16'd0, thr.double_window_ticks};
            3:    return {16'd0, thr.double_window_ticks} + 1;
            4:    return $urandom_range(0, 70000);
            5:    return $urandom;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // Mostly clean press/release pairs, with stray releases, presses on top
    // of a pending press and fully random edges mixed in.
    task automatic gen_traffic(input int n_items);
        int made;
        int pick;
        logic [TS_W-1:0] hold;
        made = 0;
        while (made < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                hold = pick_hold();
                push_edge(EDGE_PRESS, now_ts);
                push_edge(EDGE_RELEASE, now_ts + hold);
                now_ts = now_ts + hold + pick_gap();
                made += 2;
            end
            else if (pick < 85)
            begin
                push_edge(EDGE_RELEASE, now_ts);
                now_ts = now_ts + $urandom_range(0, 50);
                made += 1;
            end
            else if (pick < 93)
            begin
                push_edge(EDGE_PRESS, now_ts);
                now_ts = now_ts + $urandom_range(0, 200);
                hold = pick_hold();
                push_edge(EDGE_PRESS, now_ts);
                push_edge(EDGE_RELEASE, now_ts + hold);
                now_ts = now_ts + hold + pick_gap();
                made += 3;
            end
            else
            begin
                push_edge(1'($urandom_range(0, 1)), $urandom);
                now_ts = $urandom;
                made += 1;
            end
        end
    endtask

    initial
    begin
        first_ts   = '0;
        start_ts   = '0;
        tally      = '0;
        last_ev    = EV_RELEASE;
        press_open = 1'b0;
        thr        = '{DEBOUNCE_RST, LONG_RST, LONG3_RST, LONG5_RST, WINDOW_RST};

        // Defaults, all-zero, all-max, inverted thresholds with a wide window,
        // a tight ordered set and a few random ones.
        phase_cfg[0] = '{DEBOUNCE_RST, LONG_RST, LONG3_RST, LONG5_RST, WINDOW_RST};
        phase_cfg[1] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        phase_cfg[3] = '{16'd10, 16'd5000, 16'd3000, 16'd1000, 16'hFFFF};
        phase_cfg[4] = '{16'd100, 16'd200, 16'd400, 16'd800, 16'd50};
        for (int i = 5; i < N_PHASES; i++)
            phase_cfg[i] = '{16'($urandom_range(0, 200)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535))};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 8;
        snk_idle_pct = 73;

        // Directed edges against the reset thresholds.
        push_edge(EDGE_RELEASE, 32'h0000_0010);     // release before any press
        push_edge(EDGE_PRESS,   32'h0000_0000);
        push_edge(EDGE_RELEASE, 32'h0000_0013);     // one tick under debounce
        push_edge(EDGE_PRESS,   32'h0000_1000);
        push_edge(EDGE_RELEASE, 32'h0000_1014);     // exactly debounce: short
        push_edge(EDGE_PRESS,   32'h0000_1064);
        push_edge(EDGE_RELEASE, 32'h0000_1096);     // second tap: double
        push_edge(EDGE_RELEASE, 32'h0000_10A0);     // nothing pending: repeat
        push_edge(EDGE_PRESS,   32'h0001_0000);
        push_edge(EDGE_RELEASE, 32'h0001_03E8);     // hold at long: still short
        push_edge(EDGE_PRESS,   32'h0002_0000);
        push_edge(EDGE_RELEASE, 32'h0002_03E9);     // just over long
        push_edge(EDGE_PRESS,   32'h0003_0000);
        push_edge(EDGE_RELEASE, 32'h0003_0BB9);     // just over long3
        push_edge(EDGE_PRESS,   32'h0004_0000);
        push_edge(EDGE_RELEASE, 32'h0004_1388);     // at long5: long3
        push_edge(EDGE_PRESS,   32'h0005_0000);
        push_edge(EDGE_RELEASE, 32'h0005_1389);     // just over long5
        push_edge(EDGE_PRESS,   32'h0006_0000);
        push_edge(EDGE_PRESS,   32'h0006_0010);     // press on a pending press
        push_edge(EDGE_RELEASE, 32'h0006_0030);
        push_edge(EDGE_PRESS,   32'hFFFF_FFF0);
        push_edge(EDGE_RELEASE, 32'h0000_0010);     // hold wraps past zero
        push_edge(EDGE_PRESS,   32'hFFFF_FFFF);
        push_edge(EDGE_RELEASE, 32'hFFFF_FFFF);     // zero hold
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p < 3)
            begin
                src_idle_pct = 8;
                snk_idle_pct = 73;
            end
            else if (p < 6)
            begin
                src_idle_pct = 73;
                snk_idle_pct = 8;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_thresholds(phase_cfg[p]);
            now_ts = $urandom;
            if (p == 3)
            begin
                // Drive the tally into saturation with presses inside the window.
                for (int k = 0; k < 270; k++)
                begin
                    push_edge(EDGE_PRESS, now_ts);
                    now_ts = now_ts + $urandom_range(0, 3);
                end
                push_edge(EDGE_RELEASE, now_ts + 20);
                now_ts = now_ts + 100;
            end
            gen_traffic(80);
            // Pause the sender until the block has returned everything.
            drain();
            gen_traffic(80);
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
